@@ hw/rtl/scaled_integer_variance_core_macros.svh @@
// Assertion macros shared by the variance core modules.
`ifndef SCALED_INTEGER_VARIANCE_CORE_MACROS_SVH
`define SCALED_INTEGER_VARIANCE_CORE_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define SIV_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The condition must hold in the cycle after the trigger.
`define SIV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/siv_pkg.sv @@
// Shared types and constants of the scaled variance core.
package siv_pkg;

	localparam int SIV_SCALE_W  = 16;
	localparam int SIV_RESULT_W = 63;
	localparam int SIV_COUNT_W  = 7;
	localparam int SIV_QDEPTH   = 4;

	typedef struct packed {
		logic almost_full;
		logic not_empty;
	} siv_qstat_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL_NQ,
		BK_MUL_SS,
		BK_MUL_SC,
		BK_DIV
	} siv_bk_state_t;

endpackage

@@ hw/rtl/scaled_integer_variance_core.sv @@
// Top level of the scaled population variance core.
// Usage:
// Words enter on start, sample_value and last_of_set and are taken at an edge where
// start is high and busy is low. One word can be taken every cycle while busy is low.
// A set is the run of words up to and including one with last_of_set high; words past
// MAX_ITEMS in a set are discarded and too_many is reported with the result.
// For each closed set one result word appears on variance_scaled, item_count and
// too_many, with done high for exactly one cycle; the receiver cannot hold it off.
// Once the marked word is taken, the closed set goes through the queue to the back
// end, whose serial shift-add multiplier and one-bit-per-cycle divider form the result;
// the divider yields a PW-bit quotient, where
// PW = max(64, 2*VALUE_BITS + 2*clog2(MAX_ITEMS+1) + 16). Sets are queued
// four deep, so accumulation of the next sets overlaps this work; busy rises only
// when that queue is close to full.
// The scale register is written through scale_factor_we and scale_factor; the user
// must write it only while the core is idle, which the block itself does not enforce.
// Reset clears the accumulators, the queue and the back end and sets the scale to
// one.
module scaled_integer_variance_core #(
	parameter int MAX_ITEMS  = 64,
	parameter int VALUE_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [VALUE_BITS-1:0]         sample_value,
	input  logic                                 last_of_set,
	input  logic                                 scale_factor_we,
	input  logic [siv_pkg::SIV_SCALE_W-1:0]      scale_factor,
	output logic                                 done,
	output logic [siv_pkg::SIV_RESULT_W-1:0]     variance_scaled,
	output logic [siv_pkg::SIV_COUNT_W-1:0]      item_count,
	output logic                                 too_many
);
	import siv_pkg::*;

	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int SW = VALUE_BITS + CW;
	localparam int QW = 2 * VALUE_BITS - 2 + CW;
	localparam int DW = CW + SW + QW + 1;

	logic [SIV_SCALE_W-1:0] scale_q;
	logic                   take;
	siv_qstat_t             qstat;
	logic                   rec_push;
	logic [CW-1:0]          f_count;
	logic signed [SW-1:0]   f_sum;
	logic [QW-1:0]          f_sumsq;
	logic                   f_drop;
	logic                   rec_pop;
	logic [DW-1:0]          q_rdata;
	logic [CW-1:0]          b_count;
	logic signed [SW-1:0]   b_sum;
	logic [QW-1:0]          b_sumsq;
	logic                   b_drop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SIV_SCALE_W'(1);
		end else if (scale_factor_we) begin
			scale_q <= scale_factor;
		end
	end

	assign busy = qstat.almost_full;
	assign take = start && !busy;

	siv_front #(
		.MAX_ITEMS  (MAX_ITEMS),
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.sample_value (sample_value),
		.last_of_set  (last_of_set),
		.rec_push     (rec_push),
		.rec_count    (f_count),
		.rec_sum      (f_sum),
		.rec_sumsq    (f_sumsq),
		.rec_drop     (f_drop)
	);

	siv_queue #(
		.WIDTH (DW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rec_push),
		.wdata  ({f_count, f_sum, f_sumsq, f_drop}),
		.pop    (rec_pop),
		.rdata  (q_rdata),
		.qstat  (qstat)
	);

	assign {b_count, b_sum, b_sumsq, b_drop} = q_rdata;

	siv_back #(
		.MAX_ITEMS  (MAX_ITEMS),
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.qstat           (qstat),
		.pop             (rec_pop),
		.rec_count       (b_count),
		.rec_sum         (b_sum),
		.rec_sumsq       (b_sumsq),
		.rec_drop        (b_drop),
		.scale_factor    (scale_q),
		.done            (done),
		.variance_scaled (variance_scaled),
		.item_count      (item_count),
		.too_many        (too_many)
	);

endmodule

@@ hw/rtl/siv_front.sv @@
// Front end: squares each word, accumulates the set and closes it on the marked word.
module siv_front #(
	parameter int MAX_ITEMS  = 64,
	parameter int VALUE_BITS = 24,
	localparam int CW = $clog2(MAX_ITEMS + 1),
	localparam int SW = VALUE_BITS + CW,
	localparam int QW = 2 * VALUE_BITS - 2 + CW
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic signed [VALUE_BITS-1:0] sample_value,
	input  logic                  last_of_set,
	output logic                  rec_push,
	output logic [CW-1:0]         rec_count,
	output logic signed [SW-1:0]  rec_sum,
	output logic [QW-1:0]         rec_sumsq,
	output logic                  rec_drop
);
	import siv_pkg::*;

	localparam int SQW = 2 * VALUE_BITS - 1;

	logic [VALUE_BITS-1:0]         mag;
	logic [2*VALUE_BITS-1:0]       prod;
	logic                          v_s1;
	logic                          last_s1;
	logic signed [VALUE_BITS-1:0]  val_s1;
	logic [SQW-1:0]                sq_s1;
	logic [CW-1:0]                 count_q;
	logic signed [SW-1:0]          sum_q;
	logic [QW-1:0]                 sumsq_q;
	logic                          drop_q;
	logic                          room;

	always_comb begin
		mag  = sample_value[VALUE_BITS-1] ? VALUE_BITS'(-sample_value) : VALUE_BITS'(sample_value);
		prod = (2*VALUE_BITS)'(mag) * (2*VALUE_BITS)'(mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			last_s1 <= last_of_set;
			val_s1  <= sample_value;
			sq_s1   <= prod[SQW-1:0];
		end
	end

	always_comb begin
		room      = count_q < CW'(MAX_ITEMS);
		rec_push  = v_s1 && last_s1;
		rec_count = room ? count_q + CW'(1) : count_q;
		rec_sum   = room ? sum_q + SW'(val_s1) : sum_q;
		rec_sumsq = room ? sumsq_q + QW'(sq_s1) : sumsq_q;
		rec_drop  = drop_q || !room;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			sumsq_q <= '0;
			drop_q  <= 1'b0;
		end else if (v_s1) begin
			if (last_s1) begin
				count_q <= '0;
				sum_q   <= '0;
				sumsq_q <= '0;
				drop_q  <= 1'b0;
			end else begin
				count_q <= rec_count;
				sum_q   <= rec_sum;
				sumsq_q <= rec_sumsq;
				drop_q  <= rec_drop;
			end
		end
	end

endmodule

@@ hw/rtl/siv_queue.sv @@
// Short queue of closed sets between the front end and the back end.
`include "scaled_integer_variance_core_macros.svh"

module siv_queue #(
	parameter int WIDTH = 93
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              pop,
	output logic [WIDTH-1:0]  rdata,
	output siv_pkg::siv_qstat_t qstat
);
	import siv_pkg::*;

	localparam int AW = $clog2(SIV_QDEPTH);
	localparam int FW = $clog2(SIV_QDEPTH + 1);

	logic [WIDTH-1:0] slot_q [SIV_QDEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [FW-1:0]    fill_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(SIV_QDEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(SIV_QDEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + FW'(1);
				2'b01:   fill_q <= fill_q - FW'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_comb begin
		rdata             = slot_q[rd_ptr_q];
		qstat.not_empty   = fill_q != '0;
		qstat.almost_full = fill_q >= FW'(SIV_QDEPTH - 1);
	end

	`SIV_ASSERT_NOW(a_no_overflow, push && !pop, fill_q != FW'(SIV_QDEPTH), "queue written while full")
	`SIV_ASSERT_NOW(a_no_underflow, pop, fill_q != '0, "queue read while empty")

endmodule

@@ hw/rtl/siv_back.sv @@
// Back end: serial multiplies and a restoring divide that turn a closed set into its result.
`include "scaled_integer_variance_core_macros.svh"

module siv_back #(
	parameter int MAX_ITEMS  = 64,
	parameter int VALUE_BITS = 24,
	localparam int CW = $clog2(MAX_ITEMS + 1),
	localparam int SW = VALUE_BITS + CW,
	localparam int QW = 2 * VALUE_BITS - 2 + CW
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  siv_pkg::siv_qstat_t   qstat,
	output logic                  pop,
	input  logic [CW-1:0]         rec_count,
	input  logic signed [SW-1:0]  rec_sum,
	input  logic [QW-1:0]         rec_sumsq,
	input  logic                  rec_drop,
	input  logic [siv_pkg::SIV_SCALE_W-1:0]  scale_factor,
	output logic                  done,
	output logic [siv_pkg::SIV_RESULT_W-1:0] variance_scaled,
	output logic [siv_pkg::SIV_COUNT_W-1:0]  item_count,
	output logic                  too_many
);
	import siv_pkg::*;

	localparam int PWRAW = 2 * VALUE_BITS + 2 * CW + SIV_SCALE_W;
	localparam int PW    = (PWRAW > 64) ? PWRAW : 64;
	localparam int MW    = (SW > SIV_SCALE_W) ? SW : SIV_SCALE_W;
	localparam int NW    = 2 * CW;
	localparam int RW    = NW + 1;
	localparam int DCW   = $clog2(PW + 1);

	siv_bk_state_t state_q, state_nx;

	logic [CW-1:0]  n_q;
	logic [NW-1:0]  nsq_q;
	logic           drop_q;
	logic [SW-1:0]  sabs_q;
	logic [PW-1:0]  prod_nq_q;
	logic [PW-1:0]  acc_q;
	logic [PW-1:0]  mcand_q;
	logic [MW-1:0]  mplier_q;
	logic [RW-1:0]  rem_q;
	logic [DCW-1:0] div_cnt_q;
	logic           done_q;
	logic [SIV_RESULT_W-1:0] result_q;
	logic [SIV_COUNT_W-1:0]  count_q;
	logic           too_many_q;

	logic [SW-1:0]  sabs;
	logic           mul_done;
	logic [PW-1:0]  mul_sum;
	logic [RW-1:0]  trial;
	logic           fits;
	logic [RW-1:0]  rem_nx;
	logic [PW-1:0]  quo_nx;
	logic [SIV_RESULT_W-1:0] sat;
	logic           div_last;

	always_comb begin
		sabs     = rec_sum[SW-1] ? SW'(-rec_sum) : SW'(rec_sum);
		mul_done = mplier_q == '0;
		mul_sum  = mplier_q[0] ? acc_q + mcand_q : acc_q;
		trial    = {rem_q[RW-2:0], acc_q[PW-1]};
		fits     = trial >= RW'(nsq_q);
		rem_nx   = fits ? trial - RW'(nsq_q) : trial;
		quo_nx   = {acc_q[PW-2:0], fits};
		sat      = (|quo_nx[PW-1:SIV_RESULT_W]) ? {SIV_RESULT_W{1'b1}}
		                                        : quo_nx[SIV_RESULT_W-1:0];
		div_last = div_cnt_q == DCW'(1);
	end

	always_comb begin
		state_nx = state_q;
		pop      = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (qstat.not_empty) begin
					pop      = 1'b1;
					state_nx = BK_MUL_NQ;
				end
			end
			BK_MUL_NQ: begin
				if (mul_done) state_nx = BK_MUL_SS;
			end
			BK_MUL_SS: begin
				if (mul_done) state_nx = BK_MUL_SC;
			end
			BK_MUL_SC: begin
				if (mul_done) state_nx = BK_DIV;
			end
			BK_DIV: begin
				if (div_last) state_nx = BK_IDLE;
			end
			default: state_nx = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q  <= (state_q == BK_DIV) && div_last;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (qstat.not_empty) begin
					n_q      <= rec_count;
					nsq_q    <= NW'(rec_count) * NW'(rec_count);
					drop_q   <= rec_drop;
					sabs_q   <= sabs;
					mcand_q  <= PW'(rec_sumsq);
					mplier_q <= MW'(rec_count);
					acc_q    <= '0;
				end
			end
			BK_MUL_NQ, BK_MUL_SS, BK_MUL_SC: begin
				if (!mul_done) begin
					acc_q    <= mul_sum;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
				end else if (state_q == BK_MUL_NQ) begin
					prod_nq_q <= acc_q;
					mcand_q   <= PW'(sabs_q);
					mplier_q  <= MW'(sabs_q);
					acc_q     <= '0;
				end else if (state_q == BK_MUL_SS) begin
					mcand_q  <= prod_nq_q - acc_q;
					mplier_q <= MW'(scale_factor);
					acc_q    <= '0;
				end else begin
					rem_q     <= '0;
					div_cnt_q <= DCW'(PW);
				end
			end
			BK_DIV: begin
				acc_q     <= quo_nx;
				rem_q     <= rem_nx;
				div_cnt_q <= div_cnt_q - DCW'(1);
				if (div_last) begin
					result_q   <= sat;
					count_q    <= SIV_COUNT_W'(n_q);
					too_many_q <= drop_q;
				end
			end
			default: ;
		endcase
	end

	assign done            = done_q;
	assign variance_scaled = result_q;
	assign item_count      = count_q;
	assign too_many        = too_many_q;

	`SIV_ASSERT_NEXT(a_done_single, done_q, !done_q, "result strobe held for two cycles")
	`SIV_ASSERT_NEXT(a_pop_starts, pop, state_q == BK_MUL_NQ, "set taken without starting work")

endmodule

@@ test/scaled_integer_variance_core_tb.sv @@
// Self-checking testbench for the scaled population variance core.
module scaled_integer_variance_core_tb;

	localparam int MAX_ITEMS       = 64;
	localparam int VALUE_BITS      = 24;
	localparam int BACK_END_CYCLES = 200;
	localparam int DRAIN_LIMIT     = 20000;
	localparam int REPORT_LIMIT    = 10;

	localparam logic signed [VALUE_BITS-1:0] SAMPLE_MIN = 24'sh800000;
	localparam logic signed [VALUE_BITS-1:0] SAMPLE_MAX = 24'sh7FFFFF;

	typedef enum int {
		MODE_FULL,
		MODE_SMALL,
		MODE_EXTREME
	} sample_mode_t;

	typedef struct {
		logic [siv_pkg::SIV_RESULT_W-1:0] variance;
		logic [siv_pkg::SIV_COUNT_W-1:0]  count;
		logic                             dropped;
	} variance_word_t;

	logic                                clk;
	logic                                arst_n;
	logic                                start;
	logic                                busy;
	logic signed [VALUE_BITS-1:0]        sample_value;
	logic                                last_of_set;
	logic                                scale_factor_we;
	logic [siv_pkg::SIV_SCALE_W-1:0]     scale_factor;
	logic                                done;
	logic [siv_pkg::SIV_RESULT_W-1:0]    variance_scaled;
	logic [siv_pkg::SIV_COUNT_W-1:0]     item_count;
	logic                                too_many;

	logic [siv_pkg::SIV_SCALE_W-1:0]     model_scale;
	logic [siv_pkg::SIV_COUNT_W-1:0]     set_count;
	logic signed [30:0]                  set_sum;
	logic [52:0]                         set_square_sum;
	logic                                set_dropped;

	variance_word_t                      pending_variances[$];
	int                                  mismatch_count;
	int                                  no_idle_left;

	scaled_integer_variance_core #(
		.MAX_ITEMS (MAX_ITEMS),
		.VALUE_BITS(VALUE_BITS)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.sample_value   (sample_value),
		.last_of_set    (last_of_set),
		.scale_factor_we(scale_factor_we),
		.scale_factor   (scale_factor),
		.done           (done),
		.variance_scaled(variance_scaled),
		.item_count     (item_count),
		.too_many       (too_many)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#8000000;
		$display("scaled_integer_variance_core_tb failed");
		$finish;
	end

	task automatic clear_set_totals();
		set_count      = '0;
		set_sum        = '0;
		set_square_sum = '0;
		set_dropped    = 1'b0;
	endtask

	task automatic accumulate_sample(input logic signed [VALUE_BITS-1:0] v, input logic last);
		longint          sv;
		longint          sum_abs;
		longint unsigned mag;
		logic [127:0]    numer;
		logic [127:0]    quot;
		variance_word_t  w;
		sv = v;
		if (int'(set_count) < MAX_ITEMS) begin
			mag            = (sv < 0) ? -sv : sv;
			set_sum        = set_sum + 31'(sv);
			set_square_sum = set_square_sum + 53'(mag * mag);
			set_count      = set_count + 7'd1;
		end else begin
			set_dropped = 1'b1;
		end
		if (last) begin
			sv      = set_sum;
			sum_abs = (sv < 0) ? -sv : sv;
			numer   = 128'(set_count) * 128'(set_square_sum) - 128'(sum_abs) * 128'(sum_abs);
			quot    = (numer * 128'(model_scale)) / (128'(set_count) * 128'(set_count));
			w.variance = (quot >= (128'd1 << 63)) ? {63{1'b1}} : quot[62:0];
			w.count    = set_count;
			w.dropped  = set_dropped;
			pending_variances.push_back(w);
			clear_set_totals();
		end
	endtask

	always @(posedge clk) begin : check_result
		variance_word_t want;
		if (arst_n && done) begin
			if (pending_variances.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("unexpected result word: variance %0d count %0d too_many %0b",
						variance_scaled, item_count, too_many);
			end else begin
				want = pending_variances.pop_front();
				if (variance_scaled !== want.variance || item_count !== want.count ||
						too_many !== want.dropped) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("result word mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
							want.variance, want.count, want.dropped,
							variance_scaled, item_count, too_many);
				end
			end
		end
	end

	task automatic send_word(input logic signed [VALUE_BITS-1:0] v, input logic last);
		int gap;
		if (no_idle_left > 0) begin
			gap = 0;
			no_idle_left--;
		end else if ($urandom_range(0, 15) == 0) begin
			gap          = 0;
			no_idle_left = $urandom_range(5, 40);
		end else begin
			gap = $urandom_range(0, 12);
		end
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start        <= 1'b1;
		sample_value <= v;
		last_of_set  <= last;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		accumulate_sample(v, last);
	endtask

	task automatic wait_for_results();
		int waited;
		@(negedge clk);
		start  <= 1'b0;
		waited = 0;
		while (pending_variances.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (BACK_END_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_scale(input logic [siv_pkg::SIV_SCALE_W-1:0] v);
		@(negedge clk);
		scale_factor_we <= 1'b1;
		scale_factor    <= v;
		@(negedge clk);
		scale_factor_we <= 1'b0;
		model_scale = v;
	endtask

	function automatic logic signed [VALUE_BITS-1:0] draw_sample(input sample_mode_t mode);
		int t;
		case (mode)
			MODE_FULL: begin
				t = $urandom();
			end
			MODE_SMALL: begin
				t = int'($urandom_range(0, 40)) - 20;
			end
			default: begin
				case ($urandom_range(0, 3))
					0: t = SAMPLE_MIN;
					1: t = SAMPLE_MAX;
					2: t = 0;
					default: t = -1;
				endcase
			end
		endcase
		return t[VALUE_BITS-1:0];
	endfunction

	// Runs at the reset scale of one.
	task automatic test_reset_scale_sets();
		send_word(0, 1'b1);
		send_word(SAMPLE_MIN, 1'b1);
		send_word(SAMPLE_MAX, 1'b1);
		send_word(SAMPLE_MIN, 1'b0);
		send_word(SAMPLE_MAX, 1'b1);
		send_word(1, 1'b0);
		send_word(2, 1'b0);
		send_word(3, 1'b0);
		send_word(4, 1'b1);
		send_word(-1, 1'b0);
		send_word(-1, 1'b0);
		send_word(-1, 1'b1);
		send_word(-7, 1'b0);
		send_word(100, 1'b1);
		wait_for_results();
	endtask

	task automatic test_full_scale_extremes();
		write_scale({siv_pkg::SIV_SCALE_W{1'b1}});
		send_word(SAMPLE_MIN, 1'b0);
		send_word(SAMPLE_MAX, 1'b1);
		send_word(SAMPLE_MAX, 1'b0);
		send_word(SAMPLE_MIN, 1'b0);
		send_word(0, 1'b1);
		wait_for_results();
	endtask

	task automatic test_zero_scale();
		write_scale('0);
		send_word(3, 1'b0);
		send_word(-9, 1'b0);
		send_word(100, 1'b1);
		wait_for_results();
	endtask

	// Sets of exactly MAX_ITEMS words, one over with the marked word dropped, and well over.
	task automatic test_set_overflow();
		int sizes[3];
		sizes[0] = MAX_ITEMS;
		sizes[1] = MAX_ITEMS + 1;
		sizes[2] = MAX_ITEMS + 6;
		write_scale(siv_pkg::SIV_SCALE_W'($urandom()));
		foreach (sizes[k])
			for (int i = 0; i < sizes[k]; i++)
				send_word(draw_sample(MODE_FULL), i == sizes[k] - 1);
		wait_for_results();
	endtask

	task automatic test_random_sets(input int word_total, input logic [siv_pkg::SIV_SCALE_W-1:0] scale);
		int           sent;
		int           set_size;
		sample_mode_t mode;
		write_scale(scale);
		sent = 0;
		while (sent < word_total) begin
			set_size = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_ITEMS - 4, MAX_ITEMS + 6)
				: $urandom_range(1, 12);
			mode = sample_mode_t'($urandom_range(0, 2));
			for (int i = 0; i < set_size; i++) begin
				if ($urandom_range(0, 9) == 0)
					send_word(draw_sample(sample_mode_t'($urandom_range(0, 2))), i == set_size - 1);
				else
					send_word(draw_sample(mode), i == set_size - 1);
			end
			sent += set_size;
		end
		wait_for_results();
	endtask

	initial begin
		arst_n          = 1'b0;
		start           = 1'b0;
		sample_value    = '0;
		last_of_set     = 1'b0;
		scale_factor_we = 1'b0;
		scale_factor    = '0;
		mismatch_count  = 0;
		no_idle_left    = 0;
		model_scale     = 1;
		clear_set_totals();
		repeat (5)
			@(negedge clk);
		arst_n = 1'b1;

		test_reset_scale_sets();
		test_full_scale_extremes();
		test_zero_scale();
		test_set_overflow();
		test_random_sets(120, siv_pkg::SIV_SCALE_W'($urandom_range(2, 65534)));
		test_random_sets(90, {siv_pkg::SIV_SCALE_W{1'b1}});
		test_random_sets(40, '0);
		test_random_sets(50, 1);

		mismatch_count += pending_variances.size();
		if (mismatch_count == 0)
			$display("scaled_integer_variance_core_tb passed");
		else
			$display("scaled_integer_variance_core_tb failed");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/siv_pkg.sv
hw/rtl/siv_front.sv
hw/rtl/siv_queue.sv
hw/rtl/siv_back.sv
hw/rtl/scaled_integer_variance_core.sv
test/scaled_integer_variance_core_tb.sv
